[sv/sha256md_pkg.sv]
// ----------------------------------------------------------------------------
// sha256md_pkg
// Shared types, constants and round functions of the streaming SHA-256 core.
// ----------------------------------------------------------------------------
package sha256md_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_number;
		logic        last_word;
	} out_item_t;

	// what the front end found in an input beat
	typedef enum logic [1:0] {
		CMD_BYTE,
		CMD_END,
		CMD_BYTE_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	localparam int QDepth = 4;
	localparam int QAw    = 2;

	localparam logic [7:0] PadMark     = 8'h80;
	localparam logic [5:0] LenStart    = 6'd56;
	localparam logic [5:0] LastByte    = 6'd63;
	localparam logic [5:0] LastRound   = 6'd63;
	localparam logic [2:0] LastWordNum = 3'd7;

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic cmd_kind_t classify(input logic has_byte, input logic is_end);
		if (has_byte && is_end) begin
			classify = CMD_BYTE_END;
		end else if (has_byte) begin
			classify = CMD_BYTE;
		end else begin
			classify = CMD_END;
		end
	endfunction

endpackage

[sv/sha256md_front.sv]
// ----------------------------------------------------------------------------
// sha256md_front
// Input side: accepts message beats and turns them into queue commands.
// ----------------------------------------------------------------------------
module sha256md_front (
	input  logic                  msg_valid,
	output logic                  msg_ready,
	input  sha256md_pkg::in_item_t msg,
	input  logic                  q_full,
	output logic                  q_push,
	output sha256md_pkg::cmd_t    q_cmd
);

	assign msg_ready = !q_full;

	// a beat with neither byte nor end carries nothing and is dropped here
	assign q_push     = msg_valid && msg_ready && (msg.byte_present || msg.end_of_message);
	assign q_cmd.kind = sha256md_pkg::classify(msg.byte_present, msg.end_of_message);
	assign q_cmd.data = msg.data_byte;

endmodule

[sv/sha256md_queue.sv]
// ----------------------------------------------------------------------------
// sha256md_queue
// Small command queue between the front end and the compression engine.
// ----------------------------------------------------------------------------
module sha256md_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sha256md_pkg::cmd_t push_cmd,
	output logic               full,
	input  logic               pop,
	output logic               valid,
	output sha256md_pkg::cmd_t head
);

	sha256md_pkg::cmd_t            mem_q [sha256md_pkg::QDepth];
	logic [sha256md_pkg::QAw-1:0]  wr_q;
	logic [sha256md_pkg::QAw-1:0]  rd_q;
	logic [sha256md_pkg::QAw:0]    cnt_q;

	assign full  = (cnt_q == (sha256md_pkg::QAw+1)'(sha256md_pkg::QDepth));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[sv/sha256md_core.sv]
// ----------------------------------------------------------------------------
// sha256md_core
// Back end: packs bytes into the schedule window, pads, runs the 64 rounds
// and hands out the eight digest words.
// ----------------------------------------------------------------------------
module sha256md_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_ready,
	input  sha256md_pkg::cmd_t     q_cmd,
	output logic                   digest_valid,
	input  logic                   digest_ready,
	output sha256md_pkg::out_item_t digest
);

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_ROUND,
		ST_UPDATE,
		ST_PAD,
		ST_OUT
	} state_t;

	state_t      state_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [23:0] cur_q;
	logic [5:0]  byte_cnt_q;
	logic [60:0] len_q;
	logic [5:0]  rnd_q;
	logic [2:0]  wrd_q;
	logic        pad80_q;
	logic        len_ok_q;
	logic        final_q;
	logic        end_pend_q;
	logic        out_valid_q;
	sha256md_pkg::out_item_t out_q;

	logic        pop;
	logic        has_byte;
	logic        is_end;
	logic        coll_byte;
	logic        push_en;
	logic [7:0]  pad_byte;
	logic [7:0]  push_byte;
	logic [31:0] packed_word;
	logic        word_done;
	logic        blk_full;
	logic [63:0] len_bits;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] w_next;
	logic        out_load;

	always_comb begin
		has_byte = 1'b0;
		is_end   = 1'b0;
		unique case (q_cmd.kind)
			sha256md_pkg::CMD_BYTE: begin
				has_byte = 1'b1;
			end
			sha256md_pkg::CMD_END: begin
				is_end = 1'b1;
			end
			sha256md_pkg::CMD_BYTE_END: begin
				has_byte = 1'b1;
				is_end   = 1'b1;
			end
			default: begin
				has_byte = 1'b0;
				is_end   = 1'b0;
			end
		endcase
	end

	assign q_ready   = (state_q == ST_COLLECT);
	assign pop       = q_valid && q_ready;
	assign coll_byte = pop && has_byte;
	assign len_bits  = {len_q, 3'b000};

	// padding: mark byte, zeros, then the bit length big-endian in bytes 56..63
	always_comb begin
		if (!pad80_q) begin
			pad_byte = sha256md_pkg::PadMark;
		end else if (len_ok_q && byte_cnt_q >= sha256md_pkg::LenStart) begin
			pad_byte = len_bits[{~byte_cnt_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign push_en     = coll_byte || (state_q == ST_PAD);
	assign push_byte   = coll_byte ? q_cmd.data : pad_byte;
	assign packed_word = {cur_q, push_byte};
	assign word_done   = push_en && (byte_cnt_q[1:0] == 2'b11);
	assign blk_full    = push_en && (byte_cnt_q == sha256md_pkg::LastByte);

	// round datapath: window head is w[t], tail receives w[t+16]
	assign t1 = v_q[7] + sha256md_pkg::big_sigma1(v_q[4])
		+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ sha256md_pkg::RoundK[rnd_q] + w_q[0];
	assign t2 = sha256md_pkg::big_sigma0(v_q[0])
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign w_next = w_q[0] + sha256md_pkg::small_sigma0(w_q[1]) + w_q[9]
		+ sha256md_pkg::small_sigma1(w_q[14]);

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || digest_ready);

	assign digest_valid = out_valid_q;
	assign digest       = out_q;

	// schedule window and packing register
	always_ff @(posedge clk) begin
		if (push_en) begin
			cur_q <= packed_word[23:0];
		end
		if (word_done || state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= word_done ? packed_word : w_next;
		end
		if (out_load) begin
			out_q.digest_word <= h_q[wrd_q];
			out_q.word_number <= wrd_q;
			out_q.last_word   <= (wrd_q == sha256md_pkg::LastWordNum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha256md_pkg::InitH[i];
				v_q[i] <= '0;
			end
			byte_cnt_q  <= '0;
			len_q       <= '0;
			rnd_q       <= '0;
			wrd_q       <= '0;
			pad80_q     <= 1'b0;
			len_ok_q    <= 1'b0;
			final_q     <= 1'b0;
			end_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (push_en) begin
				byte_cnt_q <= byte_cnt_q + 1'b1;
			end
			if (coll_byte) begin
				len_q <= len_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (digest_ready) begin
				out_valid_q <= 1'b0;
			end
			if (blk_full) begin
				for (int i = 0; i < 8; i++) begin
					v_q[i] <= h_q[i];
				end
				rnd_q <= '0;
			end

			unique case (state_q)
				ST_COLLECT: begin
					if (pop) begin
						if (blk_full) begin
							end_pend_q <= is_end;
							final_q    <= 1'b0;
							state_q    <= ST_ROUND;
						end else if (is_end) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pad80_q <= 1'b1;
					if (byte_cnt_q < sha256md_pkg::LenStart) begin
						len_ok_q <= 1'b1;
					end
					if (blk_full) begin
						final_q    <= len_ok_q;
						end_pend_q <= 1'b1;
						state_q    <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					v_q[7] <= v_q[6];
					v_q[6] <= v_q[5];
					v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2];
					v_q[2] <= v_q[1];
					v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					rnd_q  <= rnd_q + 1'b1;
					if (rnd_q == sha256md_pkg::LastRound) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					if (final_q) begin
						wrd_q   <= '0;
						state_q <= ST_OUT;
					end else if (end_pend_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_COLLECT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						wrd_q <= wrd_q + 1'b1;
						if (wrd_q == sha256md_pkg::LastWordNum) begin
							for (int i = 0; i < 8; i++) begin
								h_q[i] <= sha256md_pkg::InitH[i];
							end
							byte_cnt_q <= '0;
							len_q      <= '0;
							pad80_q    <= 1'b0;
							len_ok_q   <= 1'b0;
							final_q    <= 1'b0;
							end_pend_q <= 1'b0;
							state_q    <= ST_COLLECT;
						end
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

endmodule

[sv/sha256_message_digest.sv]
// a byte that completes a 64-byte block loads the working state, then holds the intake
// for 64 rounds and one chaining update; other bytes go one per cycle while collecting.
// an end beat adds padding at one byte per cycle, one or two block compressions,
// then eight digest beats, one per cycle when not stalled.
// a four-entry command queue lets the input keep accepting during compression until full.
// reset: arst_n clears control and loads the initial hash values; no clearing pass.
// ----------------------------------------------------------------------------
// sha256_message_digest
// Streaming SHA-256: byte input, eight 32-bit digest words out per message.
// ----------------------------------------------------------------------------
module sha256_message_digest (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    msg_valid,
	output logic                    msg_ready,
	input  sha256md_pkg::in_item_t  msg,
	output logic                    digest_valid,
	input  logic                    digest_ready,
	output sha256md_pkg::out_item_t digest
);

	logic               q_full;
	logic               q_push;
	logic               q_valid;
	logic               q_ready;
	sha256md_pkg::cmd_t q_cmd;
	sha256md_pkg::cmd_t q_head;

	sha256md_front u_front (
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg       (msg),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	sha256md_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_valid && q_ready),
		.valid    (q_valid),
		.head     (q_head)
	);

	sha256md_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_cmd        (q_head),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest       (digest)
	);

	// queue never takes a beat while full
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("push into full command queue");

	// last_word flag and word index agree on every digest beat
	assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (digest.last_word == (digest.word_number == 3'd7)))
		else $error("last_word inconsistent with word_number");

	// word numbers advance by one between consecutive digest beats of a message
	assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && digest_ready && !digest.last_word) ##1 digest_valid
		|-> digest.word_number == $past(digest.word_number) + 3'd1)
		else $error("digest word order broken");

endmodule

[test/sha256_message_digest_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_message_digest_tb
// Streams byte messages into the SHA-256 core with random idle gaps on the
// input and random stalls on the digest side. Each accepted input beat goes
// through a local SHA-256 model; the digest beats that come back are checked
// field by field, in order, against the words that model produced.
// ----------------------------------------------------------------------------
module sha256_message_digest_tb;

	localparam int unsigned StimTarget = 330;
	localparam int unsigned TailCycles = 300;
	localparam int unsigned CycleLimit = 600000;

	localparam logic [31:0] RoundConst [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic                    clk;
	logic                    arst_n;
	logic                    msg_valid;
	logic                    msg_ready;
	sha256md_pkg::in_item_t  msg;
	logic                    digest_valid;
	logic                    digest_ready;
	sha256md_pkg::out_item_t digest;

	sha256_message_digest dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_ready    (msg_ready),
		.msg          (msg),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest       (digest)
	);

	// local hash state
	logic [31:0] hash_state [8];
	logic [7:0]  blk_bytes [64];
	logic [5:0]  blk_fill;
	logic [60:0] byte_total;

	sha256md_pkg::in_item_t  beats_pending [$];
	sha256md_pkg::out_item_t digest_words_due [$];
	int unsigned stim_count;
	int unsigned mismatch_count;
	int unsigned cycle_count;
	bit          msg_fire;
	int unsigned msg_gap;
	int unsigned msg_calm;
	int unsigned ready_hold;
	int unsigned ready_calm;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
		logic [63:0] twice;
		twice = {v, v} >> n;
		return twice[31:0];
	endfunction

	task automatic clear_hash();
		for (int i = 0; i < 8; i++) begin
			hash_state[i] = InitHash[i];
		end
		blk_fill = '0;
		byte_total = '0;
	endtask

	task automatic mix_block();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h;
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++) begin
			w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
		end
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
		e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ RoundConst[i] + w[i];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
		hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
	endtask

	// absorb one accepted input beat; an end beat pads and queues eight digest words
	task automatic sha_absorb(input sha256md_pkg::in_item_t it);
		logic [63:0]             bit_len;
		int                      j;
		sha256md_pkg::out_item_t word;
		if (it.byte_present) begin
			blk_bytes[blk_fill] = it.data_byte;
			blk_fill = blk_fill + 6'd1;
			byte_total = byte_total + 61'd1;
			if (blk_fill == 6'd0) begin
				mix_block();
			end
		end
		if (!it.end_of_message) begin
			return;
		end
		blk_bytes[blk_fill] = 8'h80;
		for (j = int'(blk_fill) + 1; j < 64; j++) begin
			blk_bytes[j] = 8'h00;
		end
		// no room for the length field, so it goes into an extra block
		if (blk_fill >= 6'd56) begin
			mix_block();
			for (j = 0; j < 64; j++) begin
				blk_bytes[j] = 8'h00;
			end
		end
		bit_len = {byte_total, 3'b000};
		for (j = 0; j < 8; j++) begin
			blk_bytes[56 + j] = bit_len[63 - 8*j -: 8];
		end
		mix_block();
		for (j = 0; j < 8; j++) begin
			word.digest_word = hash_state[j];
			word.word_number = 3'(j);
			word.last_word   = (j == 7);
			digest_words_due.insert(digest_words_due.size(), word);
		end
		clear_hash();
	endtask

	// mostly short gaps, a few long ones, and now and then a stretch with none
	function automatic int unsigned draw_idle(inout int unsigned calm_left);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if (r < 3) begin
			calm_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic push_beat(input logic [7:0] b, input logic has_byte, input logic is_end);
		sha256md_pkg::in_item_t it;
		it.data_byte      = b;
		it.byte_present   = has_byte;
		it.end_of_message = is_end;
		beats_pending.insert(beats_pending.size(), it);
		if (has_byte || is_end) begin
			stim_count++;
		end
	endtask

	// random bytes with a stray idle beat here and there; the end rides on the
	// last byte or comes as a beat of its own
	task automatic push_message(input int unsigned len);
		bit end_alone;
		end_alone = (len == 0) || ($urandom_range(0, 1) == 1);
		for (int unsigned k = 0; k < len; k++) begin
			if ($urandom_range(0, 15) == 0) begin
				push_beat(8'($urandom), 1'b0, 1'b0);
			end
			push_beat(8'($urandom), 1'b1, (k == len - 1) && !end_alone);
		end
		if (end_alone) begin
			push_beat(8'($urandom), 1'b0, 1'b1);
		end
	endtask

	// input driver
	always @(negedge clk) begin
		if (arst_n && (!msg_valid || msg_fire)) begin
			if (msg_gap > 0) begin
				msg_valid <= 1'b0;
				msg_gap--;
			end else if (beats_pending.size() > 0) begin
				msg_valid <= 1'b1;
				msg <= beats_pending.pop_front();
				msg_gap = draw_idle(msg_calm);
			end else begin
				msg_valid <= 1'b0;
			end
		end
	end

	// digest back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (ready_hold > 0) begin
				digest_ready <= 1'b0;
				ready_hold--;
			end else begin
				digest_ready <= 1'b1;
				ready_hold = draw_idle(ready_calm);
			end
		end
	end

	// monitor: check digest beats, then feed accepted input beats to the model
	always @(posedge clk) begin
		sha256md_pkg::out_item_t want;
		msg_fire = arst_n && msg_valid && msg_ready;
		if (arst_n && digest_valid && digest_ready) begin
			if (digest_words_due.size() == 0) begin
				$error("digest beat with no digest word due: %h", digest);
				mismatch_count++;
			end else begin
				want = digest_words_due.pop_front();
				if (digest.digest_word !== want.digest_word) begin
					$error("digest_word: expected %h, got %h", want.digest_word, digest.digest_word);
					mismatch_count++;
				end
				if (digest.word_number !== want.word_number) begin
					$error("word_number: expected %0d, got %0d", want.word_number,
						digest.word_number);
					mismatch_count++;
				end
				if (digest.last_word !== want.last_word) begin
					$error("last_word: expected %0b, got %0b", want.last_word, digest.last_word);
					mismatch_count++;
				end
			end
		end
		if (msg_fire) begin
			sha_absorb(msg);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("sha256_message_digest test failed");
			$finish;
		end
	end

	initial begin
		int unsigned len;
		msg_valid = 1'b0;
		msg = '0;
		digest_ready = 1'b0;
		arst_n = 1'b0;
		stim_count = 0;
		mismatch_count = 0;
		cycle_count = 0;
		msg_fire = 1'b0;
		msg_gap = 0;
		msg_calm = 0;
		ready_hold = 0;
		ready_calm = 0;
		for (int i = 0; i < 64; i++) begin
			blk_bytes[i] = 8'h00;
		end
		clear_hash();

		// empty message; the data on an end-only beat is ignored
		push_beat(8'hff, 1'b0, 1'b1);
		push_beat(8'h00, 1'b1, 1'b1);
		push_beat(8'hff, 1'b1, 1'b1);
		// "abc", with idle beats that carry data around it
		push_beat(8'hff, 1'b0, 1'b0);
		push_beat(8'h61, 1'b1, 1'b0);
		push_beat(8'h62, 1'b1, 1'b0);
		push_beat(8'h00, 1'b0, 1'b0);
		push_beat(8'h63, 1'b1, 1'b1);
		// a byte followed by a separate end beat
		push_beat(8'h80, 1'b1, 1'b0);
		push_beat(8'h7f, 1'b0, 1'b1);

		// block edges: length just fits, padding spills over, exactly one block
		push_message(55);
		push_message(56);
		push_message(64);
		while (stim_count < StimTarget) begin
			if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(57, 72);
			end else begin
				len = $urandom_range(0, 12);
			end
			push_message(len);
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (beats_pending.size() != 0 || msg_valid) begin
			@(posedge clk);
		end
		while (digest_words_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (TailCycles) @(posedge clk);
		if (mismatch_count == 0 && digest_words_due.size() == 0) begin
			$display("sha256_message_digest test passed");
		end else begin
			$display("sha256_message_digest test failed");
		end
		$finish;
	end

endmodule
